### design/ahrp_pkg.sv
`default_nettype none

package ahrp_pkg;

	localparam logic [1:0] RC_SUCCESS  = 2'd0;
	localparam logic [1:0] RC_INVALID  = 2'd1;
	localparam logic [1:0] RC_MISMATCH = 2'd2;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_NG  = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;

	localparam logic [15:0] SUM_INIT = 16'hFFFF;

	// first member sits in the top bits, so the packed image is the tdata layout
	typedef struct packed {
		logic [15:0] computed_sum;
		logic [15:0] received_sum;
		logic [3:0]  data_count;
		logic [63:0] data_bytes;
		logic [1:0]  reply_status;
		logic [1:0]  result_code;
	} ahrp_result_t;

endpackage

`default_nettype wire

### design/ahrp_core.sv
`default_nettype none

module ahrp_core import ahrp_pkg::*; #(
	parameter int MAX_LINE    = 64,
	parameter int MAX_PAYLOAD = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         byte_en,
	input  wire logic [7:0]   rx_byte,
	output logic              res_valid,
	output ahrp_result_t      res
);

	localparam int LenW = $clog2(MAX_LINE);
	localparam logic [LenW-1:0] LenLast = LenW'(MAX_LINE - 1);
	localparam logic [LenW-1:0] LenStatusOnly = LenW'(2);
	localparam logic [4:0] NibMax = 5'(2 * MAX_PAYLOAD);

	localparam logic [7:0] ASCII_CR    = 8'h0D;
	localparam logic [7:0] ASCII_SPACE = 8'h20;
	localparam logic [7:0] ASCII_EQ    = 8'h3D;
	localparam logic [7:0] ASCII_P     = 8'h50;
	localparam logic [7:0] ASCII_C     = 8'h43;
	localparam logic [15:0] TEXT_OK    = 16'h4F4B;
	localparam logic [15:0] TEXT_NG    = 16'h4E47;

	typedef enum logic [2:0] {
		PH_START,
		PH_TOK1,
		PH_GAP1,
		PH_TOK2,
		PH_GAP2,
		PH_TOK3,
		PH_DONE
	} phase_t;

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
		else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
		return v;
	endfunction

	phase_t            phase_q, phase_n;
	logic [LenW-1:0]   len_q, len_n;
	logic [15:0]       text_q, text_n;
	logic [1:0]        tchars_q, tchars_n;
	logic [1:0]        status_q, status_n;
	logic [63:0]       pay_q, pay_n;
	logic [4:0]        nib_q, nib_n;
	logic [15:0]       acc_q, acc_n;
	logic [15:0]       fld_q, fld_n;
	logic              err_q, err_n;
	logic              clear;

	// effect of a token separator on the current state
	phase_t            et_phase;
	logic [1:0]        et_status;
	logic              et_err;
	// state seen by a CR
	phase_t            cr_phase;
	logic [1:0]        cr_status;
	logic              cr_err;
	// state once a non-space byte opens or continues a token
	phase_t            tok_phase;
	logic [1:0]        tok_chars;
	logic [15:0]       tok_text;

	logic [4:0]        hexd;
	logic [2:0]        idx;
	logic [7:0]        pair;

	always_comb begin
		et_phase  = phase_q;
		et_status = status_q;
		et_err    = err_q;
		case (phase_q)
			PH_TOK1: begin
				et_phase = PH_GAP1;
				if (tchars_q == 2'd2 && text_q == TEXT_OK) et_status = ST_OK;
				else if (tchars_q == 2'd2 && text_q == TEXT_NG) et_status = ST_NG;
				else et_status = ST_BAD;
			end
			PH_TOK2: begin
				et_phase = PH_GAP2;
				if (!tchars_q[1]) et_err = 1'b1;
			end
			PH_TOK3: begin
				et_phase = PH_DONE;
				if (!tchars_q[1]) et_err = 1'b1;
			end
			default: ;
		endcase

		if (phase_q == PH_TOK1 || phase_q == PH_TOK3) begin
			cr_phase  = et_phase;
			cr_status = et_status;
			cr_err    = et_err;
		end else begin
			cr_phase  = phase_q;
			cr_status = status_q;
			cr_err    = err_q;
		end

		tok_phase = phase_q;
		tok_chars = tchars_q;
		tok_text  = text_q;
		case (phase_q)
			PH_START: begin
				tok_phase = PH_TOK1;
				tok_chars = '0;
				tok_text  = '0;
			end
			PH_GAP1: begin
				tok_phase = PH_TOK2;
				tok_chars = '0;
				tok_text  = '0;
			end
			PH_GAP2: begin
				tok_phase = PH_TOK3;
				tok_chars = '0;
				tok_text  = '0;
			end
			default: ;
		endcase
	end

	always_comb begin
		phase_n  = phase_q;
		len_n    = len_q;
		text_n   = text_q;
		tchars_n = tchars_q;
		status_n = status_q;
		pay_n    = pay_q;
		nib_n    = nib_q;
		acc_n    = acc_q;
		fld_n    = fld_q;
		err_n    = err_q;
		clear    = 1'b0;

		res_valid        = 1'b0;
		res              = '0;
		res.result_code  = RC_INVALID;
		res.reply_status = ST_BAD;

		hexd = hex_value(rx_byte);
		idx  = nib_q[3:1];
		pair = {pay_q[{idx, 3'd4} +: 4], hexd[3:0]};

		if (rx_byte == ASCII_CR) begin
			res_valid = 1'b1;
			clear     = 1'b1;
			if (len_q == LenStatusOnly && (cr_phase == PH_TOK1 || cr_phase == PH_GAP1)
					&& cr_status != ST_BAD) begin
				res.result_code  = RC_SUCCESS;
				res.reply_status = cr_status;
			end else if (!(cr_phase == PH_TOK3 || cr_phase == PH_DONE)
					|| cr_status == ST_BAD) begin
				res.result_code = RC_INVALID;
			end else if (cr_err || nib_q[0]) begin
				res.reply_status = cr_status;
			end else begin
				res.reply_status = cr_status;
				res.data_bytes   = pay_q;
				res.data_count   = nib_q[4:1];
				res.received_sum = fld_q;
				res.computed_sum = acc_q;
				res.result_code  = (fld_q == acc_q) ? RC_SUCCESS : RC_MISMATCH;
			end
		end else if (len_q == LenLast) begin
			// line overflow: drop the line
			res_valid = 1'b1;
			clear     = 1'b1;
		end else begin
			len_n = len_q + 1'b1;
			if (rx_byte == ASCII_SPACE) begin
				phase_n  = et_phase;
				status_n = et_status;
				err_n    = et_err;
			end else if (phase_q != PH_DONE) begin
				phase_n = tok_phase;
				text_n  = tok_text;
				case (tok_phase)
					PH_TOK1: begin
						if (!tok_chars[1]) text_n = {tok_text[7:0], rx_byte};
					end
					PH_TOK2: begin
						if (tok_chars == 2'd0) begin
							if (rx_byte != ASCII_P) err_n = 1'b1;
						end else if (tok_chars == 2'd1) begin
							if (rx_byte != ASCII_EQ) err_n = 1'b1;
						end else if (hexd[4] || nib_q >= NibMax) begin
							err_n = 1'b1;
						end else begin
							// high nibble first, then low nibble closes the byte
							if (!nib_q[0]) begin
								pay_n[{idx, 3'd4} +: 4] = hexd[3:0];
							end else begin
								pay_n[{idx, 3'd0} +: 4] = hexd[3:0];
								acc_n = acc_q - {8'd0, pair};
							end
							nib_n = nib_q + 1'b1;
						end
					end
					default: begin
						if (tok_chars == 2'd0) begin
							if (rx_byte != ASCII_C) err_n = 1'b1;
						end else if (tok_chars == 2'd1) begin
							if (rx_byte != ASCII_EQ) err_n = 1'b1;
						end else if (hexd[4]) begin
							err_n = 1'b1;
						end else begin
							fld_n = {fld_q[11:0], hexd[3:0]};
						end
					end
				endcase
				tchars_n = (tok_chars == 2'd3) ? tok_chars : tok_chars + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			len_q    <= '0;
			text_q   <= '0;
			tchars_q <= '0;
			status_q <= '0;
			pay_q    <= '0;
			nib_q    <= '0;
			acc_q    <= SUM_INIT;
			fld_q    <= '0;
			err_q    <= 1'b0;
		end else if (byte_en) begin
			if (clear) begin
				phase_q  <= PH_START;
				len_q    <= '0;
				text_q   <= '0;
				tchars_q <= '0;
				status_q <= '0;
				pay_q    <= '0;
				nib_q    <= '0;
				acc_q    <= SUM_INIT;
				fld_q    <= '0;
				err_q    <= 1'b0;
			end else begin
				phase_q  <= phase_n;
				len_q    <= len_n;
				text_q   <= text_n;
				tchars_q <= tchars_n;
				status_q <= status_n;
				pay_q    <= pay_n;
				nib_q    <= nib_n;
				acc_q    <= acc_n;
				fld_q    <= fld_n;
				err_q    <= err_n;
			end
		end
	end

endmodule

`default_nettype wire

### design/ascii_hex_reply_parser.sv
// Reply line parser for received UART bytes.
// Input stream (s_axis_*): one received byte per request in tdata[7:0]; CR (0x0D)
// closes a line. Output stream (m_axis_*): one result per CR-terminated line,
// or one when a line runs past MAX_LINE-1 bytes, carrying status, up to
// MAX_PAYLOAD decoded payload bytes, the received C= value and the computed
// checksum (0xFFFF minus the payload byte sum).
// Throughput: one byte per clock unless a pending result is not taken. Each byte is held
// in the input register and parsed there; a line's result is loaded into the
// output register that drives m_axis_tvalid when its CR byte is parsed. Bytes
// that close no line produce no output request.
// Back-pressure: a pending result is held in the output register until taken;
// meanwhile the input register still accepts one more byte, after which
// s_axis_tready drops until the result is taken.
// Reset (arst_n low, asynchronous) empties both registers and restarts the
// parser at the beginning of a line.
`default_nettype none

module ascii_hex_reply_parser import ahrp_pkg::*; #(
	parameter int MAX_LINE    = 64,
	parameter int MAX_PAYLOAD = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	input  wire logic [7:0]    s_axis_tdata,   // rx_byte
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	// result_code[1:0], reply_status[3:2], data_bytes[67:4], data_count[71:68],
	// received_sum[87:72], computed_sum[103:88]
	output logic [103:0]       m_axis_tdata
);

	logic          in_valid_s1;
	logic [7:0]    byte_s1;
	logic          advance;
	logic          res_valid;
	ahrp_result_t  res;
	logic          out_valid_q;
	ahrp_result_t  result_q;

	assign advance       = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	ahrp_core #(
		.MAX_LINE    (MAX_LINE),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (advance),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			result_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = result_q;

endmodule

`default_nettype wire
